// ===== sv/rpp_pkg.sv =====
// Package for the RIPv2 packet parser: constants, command codes, shared types
// and the mask check. No dependencies; every other file of the block uses it.
package rpp_pkg;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned OFFSET_W    = 7;
   localparam int unsigned INDEX_W     = 5;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned METRIC_W    = 5;
   localparam int unsigned CMD_W       = 2;

   localparam logic [DATA_W-1:0]   IHL_MASK     = 8'h0f;
   localparam logic [OFFSET_W-1:0] UDP_HDR_LEN  = 7'd8;
   localparam logic [COUNT_W-1:0]  RIP_HDR_LEN  = 16'd4;
   localparam logic [COUNT_W-1:0]  MIN_RIP_POS  = 16'd8;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hffff;
   localparam logic [COUNT_W-1:0]  LEN_HI_POS   = 16'd2;
   localparam logic [COUNT_W-1:0]  LEN_LO_POS   = 16'd3;
   localparam logic [INDEX_W-1:0]  ENTRY_LAST   = 5'd19;
   localparam logic [DATA_W-1:0]   RIP_VERSION  = 8'd2;
   localparam logic [WORD_W-1:0]   METRIC_MIN   = 32'd1;
   localparam logic [WORD_W-1:0]   METRIC_MAX   = 32'd16;
   localparam logic [15:0]         FAMILY_UNSPEC = 16'd0;
   localparam logic [15:0]         FAMILY_INET   = 16'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE     = 2'd0,
      CMD_REQUEST  = 2'd1,
      CMD_RESPONSE = 2'd2
   } command_type;

   // Word slots within a 20-byte route entry, selected by entry_index[4:2].
   typedef enum logic [2:0] {
      SLOT_FAMILY  = 3'd0,
      SLOT_ADDRESS = 3'd1,
      SLOT_MASK    = 3'd2,
      SLOT_HOP     = 3'd3,
      SLOT_METRIC  = 3'd4
   } slot_type;

   // Per-byte decode from the header tracker, valid in the cycle of acceptance.
   typedef struct packed {
      logic        overflow;
      logic        hdr_fail;
      logic        in_entry;
      logic        header_done;
      logic        length_match;
      command_type command;
   } pos_type;

   // A contiguous mask has ones from the top and zeros below them.
   function automatic logic mask_contiguous(input logic [WORD_W-1:0] m);
      logic [WORD_W-1:0] inv;
      inv = ~m;
      return (inv & (inv + 32'd1)) == '0;
   endfunction

endpackage

// ===== sv/rpp_if.sv =====
// Handshake channels of the RIPv2 packet parser: packet bytes in, results out.
// Depends on rpp_pkg for field widths.
interface rpp_req_if;
   logic                         valid;
   logic                         ready;
   logic [rpp_pkg::DATA_W-1:0]   data_byte;
   logic                         last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rpp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          entry_ready;
   logic [rpp_pkg::WORD_W-1:0]    route_address;
   logic [rpp_pkg::WORD_W-1:0]    route_mask;
   logic [rpp_pkg::WORD_W-1:0]    route_next_hop;
   logic [rpp_pkg::METRIC_W-1:0]  route_metric;
   logic [rpp_pkg::CMD_W-1:0]     rip_command;
   logic                          packet_done;
   logic                          packet_ok;

   modport source (output valid, output entry_ready, output route_address,
                   output route_mask, output route_next_hop, output route_metric,
                   output rip_command, output packet_done, output packet_ok,
                   input ready);
   modport sink   (input valid, input entry_ready, input route_address,
                   input route_mask, input route_next_hop, input route_metric,
                   input rip_command, input packet_done, input packet_ok,
                   output ready);
endinterface

// ===== sv/rpp_header.sv =====
// Header tracker: byte position, RIP header offset, IPv4 total length and
// RIP command; decodes where each byte falls. Depends on rpp_pkg.
module rpp_header (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [rpp_pkg::DATA_W-1:0]  data_byte,
   input  logic                        last_byte,
   output rpp_pkg::pos_type            pos
);

   logic [rpp_pkg::COUNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [rpp_pkg::OFFSET_W-1:0] rip_offset_ff, rip_offset_in;
   logic [rpp_pkg::COUNT_W-1:0]  declared_length_ff, declared_length_in;
   logic [rpp_pkg::DATA_W-1:0]   command_ff, command_in;
   logic [rpp_pkg::COUNT_W-1:0]  off0, off1, off2, off3, off4;
   logic                         overflow, past_ip;

   assign overflow = (byte_count_ff == rpp_pkg::COUNT_MAX);
   assign past_ip  = (byte_count_ff >= rpp_pkg::MIN_RIP_POS);
   assign off0     = rpp_pkg::COUNT_W'(rip_offset_ff);
   assign off1     = off0 + 16'd1;
   assign off2     = off0 + 16'd2;
   assign off3     = off0 + 16'd3;
   assign off4     = off0 + rpp_pkg::RIP_HDR_LEN;

   always_comb begin
      byte_count_in      = byte_count_ff;
      rip_offset_in      = rip_offset_ff;
      declared_length_in = declared_length_ff;
      command_in         = command_ff;
      pos.overflow       = overflow;
      pos.hdr_fail       = 1'b0;
      pos.in_entry       = 1'b0;
      if (!overflow) begin
         byte_count_in = byte_count_ff + 16'd1;
         if (byte_count_ff == '0) begin
            rip_offset_in = rpp_pkg::OFFSET_W'({data_byte & rpp_pkg::IHL_MASK, 2'b00})
                            + rpp_pkg::UDP_HDR_LEN;
         end else if (byte_count_ff == rpp_pkg::LEN_HI_POS) begin
            declared_length_in = {data_byte, declared_length_ff[7:0]};
         end else if (byte_count_ff == rpp_pkg::LEN_LO_POS) begin
            declared_length_in = {declared_length_ff[15:8], data_byte};
         end
         if (past_ip) begin
            priority if (byte_count_ff == off0) begin
               command_in   = data_byte;
               pos.hdr_fail = (data_byte != 8'(rpp_pkg::CMD_REQUEST)) &&
                              (data_byte != 8'(rpp_pkg::CMD_RESPONSE));
            end else if (byte_count_ff == off1) begin
               pos.hdr_fail = (data_byte != rpp_pkg::RIP_VERSION);
            end else if (byte_count_ff == off2 || byte_count_ff == off3) begin
               pos.hdr_fail = (data_byte != '0);
            end else if (byte_count_ff >= off4) begin
               pos.in_entry = 1'b1;
            end else begin
               pos.in_entry = 1'b0;
            end
         end
      end
      pos.header_done  = byte_count_in >=
                         (rpp_pkg::COUNT_W'(rip_offset_in) + rpp_pkg::RIP_HDR_LEN);
      pos.length_match = (byte_count_in == declared_length_in);
      if (command_in == 8'(rpp_pkg::CMD_REQUEST)) begin
         pos.command = rpp_pkg::CMD_REQUEST;
      end else if (command_in == 8'(rpp_pkg::CMD_RESPONSE)) begin
         pos.command = rpp_pkg::CMD_RESPONSE;
      end else begin
         pos.command = rpp_pkg::CMD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         byte_count_ff      <= '0;
         rip_offset_ff      <= '0;
         declared_length_ff <= '0;
         command_ff         <= '0;
      end else if (accept) begin
         byte_count_ff      <= byte_count_in;
         rip_offset_ff      <= rip_offset_in;
         declared_length_ff <= declared_length_in;
         command_ff         <= command_in;
      end
   end

endmodule

// ===== sv/rpp_entry.sv =====
// Route entry assembler: shifts entry bytes into five words and validates
// each entry on its twentieth byte. Depends on rpp_pkg.
module rpp_entry (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [rpp_pkg::DATA_W-1:0]    data_byte,
   input  logic                          last_byte,
   input  rpp_pkg::pos_type              pos,
   output logic                          entry_done,
   output logic                          entry_bad,
   output logic [rpp_pkg::WORD_W-1:0]    route_address,
   output logic [rpp_pkg::WORD_W-1:0]    route_mask,
   output logic [rpp_pkg::WORD_W-1:0]    route_next_hop,
   output logic [rpp_pkg::METRIC_W-1:0]  route_metric
);

   logic [rpp_pkg::INDEX_W-1:0] entry_index_ff, entry_index_in;
   logic [rpp_pkg::WORD_W-1:0]  family_and_tag_ff, family_and_tag_in;
   logic [rpp_pkg::WORD_W-1:0]  address_ff, address_in;
   logic [rpp_pkg::WORD_W-1:0]  mask_ff, mask_in;
   logic [rpp_pkg::WORD_W-1:0]  next_hop_ff, next_hop_in;
   logic [rpp_pkg::WORD_W-1:0]  metric_ff, metric_in;
   rpp_pkg::slot_type           slot;
   logic [15:0]                 family, tag;
   logic                        family_bad;

   assign slot = rpp_pkg::slot_type'(entry_index_ff[4:2]);

   always_comb begin
      family_and_tag_in = family_and_tag_ff;
      address_in        = address_ff;
      mask_in           = mask_ff;
      next_hop_in       = next_hop_ff;
      metric_in         = metric_ff;
      unique case (slot)
         rpp_pkg::SLOT_FAMILY:  family_and_tag_in = {family_and_tag_ff[23:0], data_byte};
         rpp_pkg::SLOT_ADDRESS: address_in        = {address_ff[23:0], data_byte};
         rpp_pkg::SLOT_MASK:    mask_in           = {mask_ff[23:0], data_byte};
         rpp_pkg::SLOT_HOP:     next_hop_in       = {next_hop_ff[23:0], data_byte};
         default:               metric_in         = {metric_ff[23:0], data_byte};
      endcase
   end

   // Family and mask are complete long before the entry's final byte; the
   // metric check must see the byte arriving now.
   assign family     = family_and_tag_ff[31:16];
   assign tag        = family_and_tag_ff[15:0];
   assign family_bad = (pos.command == rpp_pkg::CMD_REQUEST &&
                        family != rpp_pkg::FAMILY_UNSPEC) ||
                       (pos.command == rpp_pkg::CMD_RESPONSE &&
                        family != rpp_pkg::FAMILY_INET);
   assign entry_done = pos.in_entry && (entry_index_ff >= rpp_pkg::ENTRY_LAST);
   assign entry_bad  = family_bad || (tag != '0) ||
                       (metric_in < rpp_pkg::METRIC_MIN) ||
                       (metric_in > rpp_pkg::METRIC_MAX) ||
                       !rpp_pkg::mask_contiguous(mask_ff);
   assign entry_index_in = entry_done ? '0 : entry_index_ff + 5'd1;

   assign route_address  = address_ff;
   assign route_mask     = mask_ff;
   assign route_next_hop = next_hop_ff;
   assign route_metric   = metric_in[rpp_pkg::METRIC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         entry_index_ff <= '0;
      end else if (accept && pos.in_entry) begin
         entry_index_ff <= entry_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pos.in_entry) begin
         family_and_tag_ff <= family_and_tag_in;
         address_ff        <= address_in;
         mask_ff           <= mask_in;
         next_hop_ff       <= next_hop_in;
         metric_ff         <= metric_in;
      end
   end

endmodule

// ===== sv/rip_packet_parser.sv =====
// RIPv2 packet parser top level: header tracker, entry assembler, failure flag
// and result register. Depends on rpp_pkg, rpp_if, rpp_header and rpp_entry.
//
// Packet bytes enter on req_chan, starting at the IPv4 header, with last_byte
// on the final byte. Every byte is processed in the cycle it is accepted and
// its result, if any, goes into the result register on acceptance; a byte
// causes a result when it completes a route entry that passes all checks in a
// packet not yet failed, or when it is the last byte. The block takes one byte
// per clock; the only pause comes from the result register, which holds the
// input off while a result waits and rsp_chan.ready is low. After the last byte
// the byte count, header fields, entry index and failure flag are reset.
module rip_packet_parser (
   input  logic       clock,
   input  logic       reset,
   rpp_req_if.sink    req_chan,
   rpp_rsp_if.source  rsp_chan
);

   rpp_pkg::pos_type              pos;
   logic                          accept;
   logic                          entry_done, entry_bad;
   logic [rpp_pkg::WORD_W-1:0]    ent_address, ent_mask, ent_next_hop;
   logic [rpp_pkg::METRIC_W-1:0]  ent_metric;
   logic                          failed_ff, failed_in;
   logic                          fail_now, emit_entry, emit;

   logic                          rsp_valid_ff;
   logic                          entry_ready_ff;
   logic [rpp_pkg::WORD_W-1:0]    address_ff, mask_ff, next_hop_ff;
   logic [rpp_pkg::METRIC_W-1:0]  metric_ff;
   logic [rpp_pkg::CMD_W-1:0]     command_ff;
   logic                          done_ff, ok_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   rpp_header u_header (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .pos       (pos)
   );

   rpp_entry u_entry (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_chan.data_byte),
      .last_byte      (req_chan.last_byte),
      .pos            (pos),
      .entry_done     (entry_done),
      .entry_bad      (entry_bad),
      .route_address  (ent_address),
      .route_mask     (ent_mask),
      .route_next_hop (ent_next_hop),
      .route_metric   (ent_metric)
   );

   assign fail_now   = pos.overflow || pos.hdr_fail || (entry_done && entry_bad);
   assign emit_entry = entry_done && !entry_bad && !failed_ff;
   assign emit       = emit_entry || req_chan.last_byte;
   assign failed_in  = failed_ff || fail_now;

   always_ff @(posedge clock) begin
      if (reset || (accept && req_chan.last_byte)) begin
         failed_ff <= 1'b0;
      end else if (accept) begin
         failed_ff <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         entry_ready_ff <= emit_entry;
         address_ff     <= emit_entry ? ent_address  : '0;
         mask_ff        <= emit_entry ? ent_mask     : '0;
         next_hop_ff    <= emit_entry ? ent_next_hop : '0;
         metric_ff      <= emit_entry ? ent_metric   : '0;
         command_ff     <= pos.command;
         done_ff        <= req_chan.last_byte;
         ok_ff          <= req_chan.last_byte && !failed_in &&
                           pos.header_done && pos.length_match;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.entry_ready    = entry_ready_ff;
   assign rsp_chan.route_address  = address_ff;
   assign rsp_chan.route_mask     = mask_ff;
   assign rsp_chan.route_next_hop = next_hop_ff;
   assign rsp_chan.route_metric   = metric_ff;
   assign rsp_chan.rip_command    = command_ff;
   assign rsp_chan.packet_done    = done_ff;
   assign rsp_chan.packet_ok      = ok_ff;

   // A validated entry always carries a metric in range and a known command.
   a_entry_metric: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && entry_ready_ff |-> metric_ff != '0 && metric_ff <= 5'd16)
      else $error("entry emitted with metric out of range");

   a_entry_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && entry_ready_ff |-> command_ff != rpp_pkg::CMD_NONE)
      else $error("entry emitted without a valid command");

   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ok_ff |-> done_ff)
      else $error("packet_ok without packet_done");

   a_fail_cleared: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.last_byte |=> !failed_ff)
      else $error("failure flag survived the end of a packet");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.last_byte |=> rsp_valid_ff && done_ff)
      else $error("last byte produced no packet_done result");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the RIPv2 packet parser: builds IPv4/RIP packets, predicts each result word
// and checks it against the block. Depends on rpp_pkg, rpp_if and rip_packet_parser.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rpp_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 11;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_BYTES    = 40;
   localparam int MAX_REPORTS     = 10;
   localparam int MAX_GAP         = 9;
   localparam logic [3:0] IPV4_VERSION = 4'd4;

   typedef enum int {
      FLAW_NONE, FLAW_COMMAND, FLAW_VERSION, FLAW_ZERO, FLAW_FAMILY, FLAW_TAG,
      FLAW_METRIC, FLAW_MASK, FLAW_LENGTH, FLAW_TRUNCATE, FLAW_TRAILER, FLAW_NOISE
   } flaw_type;

   typedef struct packed {
      logic                entry;
      logic [WORD_W-1:0]   address;
      logic [WORD_W-1:0]   mask;
      logic [WORD_W-1:0]   next_hop;
      logic [METRIC_W-1:0] metric;
      logic [CMD_W-1:0]    command;
      logic                done;
      logic                ok;
   } route_report_type;

   bit   clock;
   logic reset = 1'b1;

   rpp_req_if req_chan ();
   rpp_rsp_if rsp_chan ();

   rip_packet_parser DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Parser state as the testbench tracks it.
   logic [COUNT_W-1:0]  seen_bytes;
   logic [OFFSET_W-1:0] rip_hdr_pos;
   logic [COUNT_W-1:0]  total_len;
   logic [DATA_W-1:0]   cmd_byte;
   logic                bad_flag;
   logic [INDEX_W-1:0]  entry_pos;
   logic [WORD_W-1:0]   fam_tag_acc;
   logic [WORD_W-1:0]   addr_acc;
   logic [WORD_W-1:0]   mask_acc;
   logic [WORD_W-1:0]   hop_acc;
   logic [WORD_W-1:0]   metric_acc;

   route_report_type  route_reports[$];
   logic [DATA_W-1:0] pkt_bytes[$];
   int mismatch_count = 0;
   int quiet_cycles = 0;
   bit no_idle;
   bit hold_off_req;

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   function automatic void clear_parser();
      seen_bytes  = '0;
      rip_hdr_pos = '0;
      total_len   = '0;
      cmd_byte    = '0;
      bad_flag    = 1'b0;
      entry_pos   = '0;
      fam_tag_acc = '0;
      addr_acc    = '0;
      mask_acc    = '0;
      hop_acc     = '0;
      metric_acc  = '0;
   endfunction

   // Ones from the top, then only zeros.
   function automatic logic is_prefix_mask(input logic [WORD_W-1:0] m);
      logic hit_zero;
      hit_zero = 1'b0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (hit_zero && m[i]) return 1'b0;
         if (!m[i]) hit_zero = 1'b1;
      end
      return 1'b1;
   endfunction

   // Advances the parser state by one accepted byte and queues the result word it causes.
   function automatic void parse_byte(input logic [DATA_W-1:0] b, input logic last);
      int               pos;
      int               start;
      logic             emit;
      logic             wrong;
      logic [15:0]      family;
      logic [15:0]      tag;
      route_report_type r;
      pos  = int'(seen_bytes);
      emit = 1'b0;
      if (seen_bytes == COUNT_MAX) begin
         bad_flag = 1'b1;
      end else begin
         seen_bytes = seen_bytes + 16'd1;
         if (pos == 0) begin
            rip_hdr_pos = OFFSET_W'({b[3:0], 2'b00}) + UDP_HDR_LEN;
         end else if (pos == int'(LEN_HI_POS)) begin
            total_len[15:8] = b;
         end else if (pos == int'(LEN_LO_POS)) begin
            total_len[7:0] = b;
         end
         start = int'(rip_hdr_pos);
         if (pos >= int'(MIN_RIP_POS)) begin
            if (pos == start) begin
               cmd_byte = b;
               if (b != 8'(CMD_REQUEST) && b != 8'(CMD_RESPONSE)) bad_flag = 1'b1;
            end else if (pos == start + 1) begin
               if (b != RIP_VERSION) bad_flag = 1'b1;
            end else if (pos == start + 2 || pos == start + 3) begin
               if (b != 8'd0) bad_flag = 1'b1;
            end else if (pos >= start + int'(RIP_HDR_LEN)) begin
               case (slot_type'(entry_pos[4:2]))
                  SLOT_FAMILY:  fam_tag_acc = {fam_tag_acc[23:0], b};
                  SLOT_ADDRESS: addr_acc    = {addr_acc[23:0], b};
                  SLOT_MASK:    mask_acc    = {mask_acc[23:0], b};
                  SLOT_HOP:     hop_acc     = {hop_acc[23:0], b};
                  default:      metric_acc  = {metric_acc[23:0], b};
               endcase
               if (entry_pos >= ENTRY_LAST) begin
                  family = fam_tag_acc[31:16];
                  tag    = fam_tag_acc[15:0];
                  wrong  = (cmd_byte == 8'(CMD_REQUEST) && family != FAMILY_UNSPEC) ||
                           (cmd_byte == 8'(CMD_RESPONSE) && family != FAMILY_INET) ||
                           tag != 16'd0 || metric_acc < METRIC_MIN ||
                           metric_acc > METRIC_MAX || !is_prefix_mask(mask_acc);
                  if (wrong) bad_flag = 1'b1;
                  else if (!bad_flag) emit = 1'b1;
                  entry_pos = '0;
               end else begin
                  entry_pos = entry_pos + 5'd1;
               end
            end
         end
      end

      if (emit || last) begin
         r = '0;
         if (emit) begin
            r.entry    = 1'b1;
            r.address  = addr_acc;
            r.mask     = mask_acc;
            r.next_hop = hop_acc;
            r.metric   = metric_acc[METRIC_W-1:0];
         end
         if (cmd_byte == 8'(CMD_REQUEST) || cmd_byte == 8'(CMD_RESPONSE)) begin
            r.command = cmd_byte[CMD_W-1:0];
         end else begin
            r.command = CMD_NONE;
         end
         if (last) begin
            r.done = 1'b1;
            r.ok   = !bad_flag && rip_hdr_pos >= UDP_HDR_LEN &&
                     int'(seen_bytes) >= int'(rip_hdr_pos) + int'(RIP_HDR_LEN) &&
                     seen_bytes == total_len;
            clear_parser();
         end
         route_reports.push_back(r);
      end
   endfunction

   function automatic string report_text(input route_report_type r);
      return $sformatf({"entry=%0b addr=%08h mask=%08h hop=%08h metric=%0d",
                        " cmd=%0d done=%0b ok=%0b"},
                       r.entry, r.address, r.mask, r.next_hop, r.metric, r.command,
                       r.done, r.ok);
   endfunction

   function automatic void check_report();
      route_report_type got;
      route_report_type want;
      got.entry    = rsp_chan.entry_ready;
      got.address  = rsp_chan.route_address;
      got.mask     = rsp_chan.route_mask;
      got.next_hop = rsp_chan.route_next_hop;
      got.metric   = rsp_chan.route_metric;
      got.command  = rsp_chan.rip_command;
      got.done     = rsp_chan.packet_done;
      got.ok       = rsp_chan.packet_ok;
      if (route_reports.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result word with nothing expected: %s", $realtime, report_text(got));
         return;
      end
      want = route_reports.pop_front();
      if (got.entry !== want.entry || got.address !== want.address ||
          got.mask !== want.mask || got.next_hop !== want.next_hop ||
          got.metric !== want.metric || got.command !== want.command ||
          got.done !== want.done || got.ok !== want.ok) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch", $realtime);
            $display("   expected %s", report_text(want));
            $display("   actual   %s", report_text(got));
         end
      end
   endfunction

   function automatic void push_be(input logic [WORD_W-1:0] w);
      for (int i = 3; i >= 0; i--) pkt_bytes.push_back(w[8*i +: 8]);
   endfunction

   function automatic logic [WORD_W-1:0] prefix_mask(input int n);
      return (n == 0) ? 32'd0 : (32'hffff_ffff << (32 - n));
   endfunction

   function automatic void set_length(input int len);
      logic [15:0] l;
      l = 16'(len);
      pkt_bytes[2] = l[15:8];
      pkt_bytes[3] = l[7:0];
   endfunction

   // Builds one packet into pkt_bytes. For entry flaws flaw_at picks the broken entry,
   // for truncation it is the length kept; a negative value draws it at random.
   function automatic void build_packet(input int ihl, input int cmd, input int n_entries,
                                        input flaw_type flaw, input int flaw_at,
                                        input bit extremes);
      int               rip_pos;
      int               bad_entry;
      int               prefix;
      int               cut;
      int               v;
      int               corners[4] = '{0, 32, 1, 31};
      logic [15:0]      family;
      logic [15:0]      tag;
      logic [WORD_W-1:0] address;
      logic [WORD_W-1:0] mask;
      logic [WORD_W-1:0] hop;
      logic [WORD_W-1:0] metric;
      pkt_bytes.delete();
      if (flaw == FLAW_NOISE) begin
         repeat ($urandom_range(1, 60)) pkt_bytes.push_back(8'($urandom));
         return;
      end
      if (flaw_at >= 0 && flaw_at < n_entries) bad_entry = flaw_at;
      else if (n_entries > 0) bad_entry = int'($urandom_range(0, n_entries - 1));
      else bad_entry = -1;

      rip_pos = ihl * 4 + int'(UDP_HDR_LEN);
      pkt_bytes.push_back({IPV4_VERSION, 4'(ihl)});
      for (int i = 1; i < rip_pos; i++) pkt_bytes.push_back(8'($urandom));

      if (flaw == FLAW_COMMAND) begin
         case ($urandom_range(0, 2))
            0:       pkt_bytes.push_back(8'd0);
            1:       pkt_bytes.push_back(8'd3);
            default: pkt_bytes.push_back(8'($urandom_range(3, 255)));
         endcase
      end else begin
         pkt_bytes.push_back(8'(cmd));
      end
      if (flaw == FLAW_VERSION) begin
         v = int'($urandom_range(0, 254));
         if (v >= int'(RIP_VERSION)) v++;
         pkt_bytes.push_back(8'(v));
      end else begin
         pkt_bytes.push_back(RIP_VERSION);
      end
      if (flaw == FLAW_ZERO && $urandom_range(0, 1) == 1) begin
         pkt_bytes.push_back(8'($urandom_range(1, 255)));
         pkt_bytes.push_back(8'($urandom));
      end else if (flaw == FLAW_ZERO) begin
         pkt_bytes.push_back(8'd0);
         pkt_bytes.push_back(8'($urandom_range(1, 255)));
      end else begin
         pkt_bytes.push_back(8'd0);
         pkt_bytes.push_back(8'd0);
      end

      for (int k = 0; k < n_entries; k++) begin
         family  = (cmd == CMD_REQUEST) ? FAMILY_UNSPEC : FAMILY_INET;
         tag     = 16'd0;
         prefix  = extremes ? corners[k % 4] : int'($urandom_range(0, 32));
         mask    = prefix_mask(prefix);
         address = extremes ? ((k % 2 == 1) ? 32'hffff_ffff : 32'd0) : $urandom;
         hop     = extremes ? ((k % 2 == 1) ? 32'd0 : 32'hffff_ffff) : $urandom;
         metric  = extremes ? ((k % 2 == 1) ? METRIC_MAX : METRIC_MIN)
                            : 32'($urandom_range(1, 16));
         if (k == bad_entry) begin
            case (flaw)
               FLAW_FAMILY: begin
                  if (cmd == CMD_REQUEST) family = FAMILY_INET;
                  else if ($urandom_range(0, 1) == 1) family = FAMILY_UNSPEC;
                  else family = 16'($urandom_range(3, 65535));
               end
               FLAW_TAG: tag = 16'($urandom_range(1, 65535));
               FLAW_METRIC: begin
                  case ($urandom_range(0, 2))
                     0:       metric = 32'd0;
                     1:       metric = METRIC_MAX + 32'd1;
                     default: metric = $urandom | 32'h100;
                  endcase
               end
               FLAW_MASK: begin
                  // A set bit below the first zero leaves a hole in the mask.
                  prefix = int'($urandom_range(0, 30));
                  mask   = prefix_mask(prefix) | (32'd1 << $urandom_range(0, 30 - prefix));
               end
               default: ;
            endcase
         end
         push_be({family, tag});
         push_be(address);
         push_be(mask);
         push_be(hop);
         push_be(metric);
      end

      if (flaw == FLAW_TRAILER)
         repeat ($urandom_range(1, 19)) pkt_bytes.push_back(8'($urandom));
      if (flaw == FLAW_LENGTH)
         set_length(pkt_bytes.size() + int'($urandom_range(1, 65535)));
      else
         set_length(pkt_bytes.size());
      if (flaw == FLAW_TRUNCATE) begin
         cut = (flaw_at >= 1) ? flaw_at : int'($urandom_range(1, rip_pos + 3));
         while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end
   endfunction

   task automatic send_byte(input logic [DATA_W-1:0] b, input logic last);
      int gap;
      gap = no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
      if (gap > 0) begin
         @(negedge clock) req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.last_byte <= last;
      do @(posedge clock); while (!req_chan.ready);
      parse_byte(b, last);
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt_bytes.size(); i++)
         send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
   endtask

   task automatic test_well_formed();
      build_packet(0, CMD_RESPONSE, 4, FLAW_NONE, -1, 1'b1);
      send_packet();
      // Header length zero puts the RIP header right at byte 8.
      build_packet(0, CMD_REQUEST, 1, FLAW_NONE, -1, 1'b0);
      send_packet();
      // The largest header length puts the RIP header at byte 68.
      build_packet(15, CMD_REQUEST, 0, FLAW_NONE, -1, 1'b0);
      send_packet();
      build_packet(0, CMD_RESPONSE, 0, FLAW_TRAILER, -1, 1'b0);
      send_packet();
   endtask

   task automatic test_header_faults();
      repeat (2) begin
         build_packet(0, CMD_RESPONSE, 0, FLAW_COMMAND, -1, 1'b0);
         send_packet();
      end
      build_packet(0, CMD_REQUEST, 0, FLAW_VERSION, -1, 1'b0);
      send_packet();
      build_packet(0, CMD_RESPONSE, 0, FLAW_ZERO, -1, 1'b0);
      send_packet();
      build_packet(0, CMD_RESPONSE, 0, FLAW_LENGTH, -1, 1'b0);
      send_packet();
      // Short packets: a single byte, and one byte short of a full RIP header.
      build_packet(5, CMD_RESPONSE, 0, FLAW_TRUNCATE, 1, 1'b0);
      send_packet();
      build_packet(0, CMD_RESPONSE, 0, FLAW_TRUNCATE, 11, 1'b0);
      send_packet();
      build_packet(2, CMD_REQUEST, 0, FLAW_TRUNCATE, -1, 1'b0);
      send_packet();
      build_packet(5, CMD_REQUEST, 0, FLAW_NOISE, -1, 1'b0);
      send_packet();
   endtask

   task automatic test_entry_faults();
      // A bad first entry must suppress the good one after it.
      build_packet(0, CMD_REQUEST, 2, FLAW_FAMILY, 0, 1'b0);
      send_packet();
      build_packet(0, CMD_RESPONSE, 2, FLAW_FAMILY, 1, 1'b0);
      send_packet();
      build_packet(0, CMD_RESPONSE, 1, FLAW_TAG, 0, 1'b0);
      send_packet();
      build_packet(0, CMD_RESPONSE, 1, FLAW_METRIC, 0, 1'b0);
      send_packet();
      build_packet(0, CMD_REQUEST, 1, FLAW_MASK, 0, 1'b0);
      send_packet();
   endtask

   // The hold-off starts after the next result word; a later entry's word then waits
   // in the block while the sender keeps offering bytes.
   task automatic test_backpressure();
      no_idle      = 1'b1;
      hold_off_req = 1'b1;
      build_packet(0, CMD_RESPONSE, 3, FLAW_NONE, -1, 1'b0);
      send_packet();
      no_idle = 1'b0;
   endtask

   task automatic test_random();
      int       sent;
      int       ihl;
      int       cmd;
      int       n;
      flaw_type flaw;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         no_idle = ($urandom_range(0, 4) == 0);
         ihl  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 15)) : 5;
         cmd  = ($urandom_range(0, 1) == 1) ? CMD_RESPONSE : CMD_REQUEST;
         n    = int'($urandom_range(0, 4));
         flaw = ($urandom_range(0, 9) < 7) ? FLAW_NONE
                : flaw_type'($urandom_range(FLAW_COMMAND, FLAW_NOISE));
         build_packet(ihl, cmd, n, flaw, -1, 1'b0);
         sent += pkt_bytes.size();
         send_packet();
      end
      no_idle = 1'b0;
   endtask

   // Result side: random stalls per word, one long hold-off on request.
   initial begin : result_sink
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         if (hold_off_req) begin
            @(negedge clock) rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         stall = no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
         if (stall > 0) begin
            @(negedge clock) rsp_chan.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         check_report();
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : test_sequence
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      clear_parser();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_well_formed();
      test_header_faults();
      test_entry_faults();
      test_backpressure();
      test_random();

      @(negedge clock) req_chan.valid <= 1'b0;
      while (route_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
